// File: src/qetf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helpers for the quintic escape-time fractal core.
package qetf_pkg;

    // Field widths
    localparam int COORD_BITS     = 12;
    localparam int FRAC_BITS      = 36;
    localparam int ITER_BITS      = 16;
    localparam int WORD_BITS      = 48;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = WORD_BITS;

    // Stream word widths, padded to whole bytes
    localparam int IN_FIELD_BITS  = 2 * COORD_BITS;
    localparam int IN_DATA_BITS   = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 2 * COORD_BITS + ITER_BITS + 1;
    localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Multiplier operand and product widths. Operands stay below 2^49 in
    // magnitude; products below 2^53 after the fraction shift.
    localparam int OP_W   = 52;
    localparam int HALF_W = OP_W / 2;
    localparam int ACC_W  = 2 * OP_W;
    localparam int RES_W  = 56;

    // Polynomial sums (|re|, |im| < 16 * 2^51 + 2^47) and pixel mapping
    localparam int SUM_W  = 58;
    localparam int MAP_W  = COORD_BITS + WORD_BITS + 2;
    localparam int SAT_W  = (MAP_W > SUM_W) ? MAP_W : SUM_W;
    localparam int MAG2_W = RES_W + 1;

    // Escape thresholds as powers of two of the raw fixed point value
    localparam int ESC_MAG_EXP   = 8 + FRAC_BITS;               // |x| >= 256
    localparam int ESCAPE_EXP    = 16 + FRAC_BITS;              // |z|^2 >= 65536
    localparam int GATE_EXP      = (97 - 2 * FRAC_BITS) / 5 + 1;
    localparam int GATE_LIM_EXP  = GATE_EXP + FRAC_BITS;        // z^5 surely leaves the word

    localparam logic [ITER_BITS-1:0] LIMIT_RESET = ITER_BITS'(64);

    localparam logic signed [SAT_W-1:0] SAT_WORD_MAX =
        signed'((SAT_W'(1) << (WORD_BITS - 1)) - SAT_W'(1));
    localparam logic signed [SAT_W-1:0] SAT_WORD_MIN =
        -signed'(SAT_W'(1) << (WORD_BITS - 1));

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_STEP_REAL   = 3'd0,
        REG_STEP_IMAG   = 3'd1,
        REG_ORIGIN_REAL = 3'd2,
        REG_ORIGIN_IMAG = 3'd3,
        REG_ITER_LIMIT  = 3'd4
    } cfg_reg_t;

    // Product schedule of one iteration
    typedef enum logic [3:0] {
        OP_XX   = 4'd0,
        OP_YY   = 4'd1,
        OP_X3   = 4'd2,
        OP_X4   = 4'd3,
        OP_X5   = 4'd4,
        OP_Y3   = 4'd5,
        OP_Y4   = 4'd6,
        OP_Y5   = 4'd7,
        OP_X3Y2 = 4'd8,
        OP_XY4  = 4'd9,
        OP_YX4  = 4'd10,
        OP_Y3X2 = 4'd11
    } op_t;

    // Multiplier request: operands are two's complement
    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] a;
        logic [OP_W-1:0] b;
    } mul_req_t;

    // Multiplier response: p = floor(a * b / 2^FRAC_BITS), two's complement
    typedef struct packed {
        logic             done;
        logic [RES_W-1:0] p;
    } mul_rsp_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic                 ovf;
    } sat_t;

    function automatic sat_t sat_word(input logic signed [SAT_W-1:0] v);
        sat_t r;
        if (v > SAT_WORD_MAX)
        begin
            r.value = SAT_WORD_MAX[WORD_BITS-1:0];
            r.ovf   = 1'b1;
        end
        else if (v < SAT_WORD_MIN)
        begin
            r.value = SAT_WORD_MIN[WORD_BITS-1:0];
            r.ovf   = 1'b1;
        end
        else
        begin
            r.value = v[WORD_BITS-1:0];
            r.ovf   = 1'b0;
        end
        return r;
    endfunction

endpackage

// File: src/qetf_mul.sv
`timescale 1ns / 1ps
// Sequential fixed point multiplier: four half-width partial products per request.
module qetf_mul (
    input  logic                clk,
    input  logic                rst_n,
    input  qetf_pkg::mul_req_t  req,
    output qetf_pkg::mul_rsp_t  rsp
);
    import qetf_pkg::*;

    localparam logic [2:0] PP_LAST  = 3'd3;   // last partial product step
    localparam logic [2:0] FIN_STEP = 3'd5;   // accumulator complete

    logic [OP_W-1:0]     a_mag;
    logic [OP_W-1:0]     b_mag;
    logic [HALF_W-1:0]   a_half;
    logic [HALF_W-1:0]   b_half;
    logic [2*HALF_W-1:0] pp_next;
    logic [1:0]          sh_next;
    logic [ACC_W-1:0]    pp_aligned;
    logic signed [ACC_W:0] acc_s;
    logic signed [ACC_W:0] fin_s;
    logic signed [ACC_W:0] fin_shift;

    logic                busy_reg;
    logic                done_reg;
    logic                ppv_reg;
    logic [2:0]          step_reg;
    logic [OP_W-1:0]     ua_reg;
    logic [OP_W-1:0]     ub_reg;
    logic                neg_reg;
    logic [2*HALF_W-1:0] pp_reg;
    logic [1:0]          pp_sh_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [RES_W-1:0]    p_reg;

    assign a_mag = req.a[OP_W-1] ? (OP_W'(0) - req.a) : req.a;
    assign b_mag = req.b[OP_W-1] ? (OP_W'(0) - req.b) : req.b;

    assign a_half  = step_reg[0] ? ua_reg[OP_W-1:HALF_W] : ua_reg[HALF_W-1:0];
    assign b_half  = step_reg[1] ? ub_reg[OP_W-1:HALF_W] : ub_reg[HALF_W-1:0];
    assign pp_next = a_half * b_half;
    assign sh_next = {1'b0, step_reg[0]} + {1'b0, step_reg[1]};

    always_comb
    begin
        case (pp_sh_reg)
            2'd0:    pp_aligned = ACC_W'(pp_reg);
            2'd1:    pp_aligned = ACC_W'(pp_reg) << HALF_W;
            default: pp_aligned = ACC_W'(pp_reg) << (2 * HALF_W);
        endcase
    end

    // Negating before the arithmetic shift gives floor for negative products
    assign acc_s     = signed'({1'b0, acc_reg});
    assign fin_s     = neg_reg ? -acc_s : acc_s;
    assign fin_shift = fin_s >>> FRAC_BITS;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ppv_reg  <= 1'b0;
            step_reg <= 3'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                ppv_reg  <= 1'b0;
                step_reg <= 3'd0;
            end
            else if (busy_reg)
            begin
                ppv_reg  <= (step_reg <= PP_LAST);
                step_reg <= step_reg + 3'd1;
                if (step_reg == FIN_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            ua_reg  <= a_mag;
            ub_reg  <= b_mag;
            neg_reg <= req.a[OP_W-1] ^ req.b[OP_W-1];
            acc_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (step_reg <= PP_LAST)
            begin
                pp_reg    <= pp_next;
                pp_sh_reg <= sh_next;
            end
            if (ppv_reg)
            begin
                acc_reg <= acc_reg + pp_aligned;
            end
            if (step_reg == FIN_STEP)
            begin
                p_reg <= fin_shift[RES_W-1:0];
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.p    = p_reg;

endmodule

// File: src/quintic_escape_time_fractal_core.sv
`timescale 1ns / 1ps
// Top level of the quintic escape-time fractal core: pixel in, iteration count out.
//
// Each input word carries one pixel (column, row). The core maps it to
// c = (col * step_real + origin_real, row * step_imag + origin_imag) in signed
// Q12.36, saturated to 48 bits, then iterates z = z^5 + c from z = 0 until
// |z|^2 reaches 65536, the new z saturates, or iteration_limit iterations are
// done, and returns one word with the pixel, the iteration count and an escaped
// flag (count below the limit). Once |z|^2 reaches 64 the next z would surely
// saturate, so that iteration is counted without being computed and the pixel
// ends. The iteration products run on a single shared fixed point multiplier
// built from one 26x26 multiplier: every 52-bit product takes four partial
// products. One iteration uses 12 products (two for the escape test, ten for
// z^5); the pixel mapping has its own 13x48 multiplier. One pixel is in flight
// at a time; s_tready is high only between pixels. The result sits in an
// output register, so the next pixel is accepted while the previous result
// waits for m_tready. Configuration words may be written at any cycle
// (cfg_ready is always high) but must only be changed between pixels; the
// limit is sampled when a pixel is accepted. A limit of zero returns count 0.
module quintic_escape_time_fractal_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // pixel input: [11:0] pixel_col, [23:12] pixel_row
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [qetf_pkg::IN_DATA_BITS-1:0]      s_tdata,
    // result: [11:0] col_tag, [23:12] row_tag, [39:24] iter_count, [40] escaped
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [qetf_pkg::OUT_DATA_BITS-1:0]     m_tdata,
    // configuration write channel
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [qetf_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [qetf_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
    import qetf_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE    = 9'b000000001,
        S_MAP_RE  = 9'b000000010,
        S_MAP_IM  = 9'b000000100,
        S_MAP_FIN = 9'b000001000,
        S_CHECK   = 9'b000010000,
        S_MUL     = 9'b000100000,
        S_TEST    = 9'b001000000,
        S_UPDATE  = 9'b010000000,
        S_FINISH  = 9'b100000000
    } state_t;

    localparam logic signed [WORD_BITS-1:0] ESC_POS =
        signed'(WORD_BITS'(1) << ESC_MAG_EXP);
    localparam logic signed [WORD_BITS-1:0] ESC_NEG = -ESC_POS;
    localparam logic [MAG2_W-1:0] MAG2_ESCAPE = MAG2_W'(1) << ESCAPE_EXP;
    localparam logic [MAG2_W-1:0] MAG2_GATE   = MAG2_W'(1) << GATE_LIM_EXP;

    // ---------------- configuration registers ----------------
    logic signed [WORD_BITS-1:0] step_real_reg,   step_real_next;
    logic signed [WORD_BITS-1:0] step_imag_reg,   step_imag_next;
    logic signed [WORD_BITS-1:0] origin_real_reg, origin_real_next;
    logic signed [WORD_BITS-1:0] origin_imag_reg, origin_imag_next;
    logic [ITER_BITS-1:0]        iter_limit_reg,  iter_limit_next;

    // ---------------- sequencer and datapath ----------------
    state_t                      state_reg,      state_next;
    op_t                         op_reg,         op_next;
    logic                        mul_start_reg,  mul_start_next;
    logic                        out_valid_reg,  out_valid_next;
    logic [OUT_DATA_BITS-1:0]    out_data_reg,   out_data_next;
    logic [COORD_BITS-1:0]       col_reg,        col_next;
    logic [COORD_BITS-1:0]       row_reg,        row_next;
    logic [ITER_BITS-1:0]        lim_reg,        lim_next;
    logic [ITER_BITS-1:0]        count_reg,      count_next;
    logic signed [COORD_BITS+WORD_BITS:0] map_prod_reg, map_prod_next;
    logic signed [WORD_BITS-1:0] cr_reg,         cr_next;
    logic signed [WORD_BITS-1:0] ci_reg,         ci_next;
    logic signed [WORD_BITS-1:0] x_reg,          x_next;
    logic signed [WORD_BITS-1:0] y_reg,          y_next;
    logic signed [RES_W-1:0]     x2_reg,         x2_next;
    logic signed [RES_W-1:0]     y2_reg,         y2_next;
    logic signed [RES_W-1:0]     x3_reg,         x3_next;
    logic signed [RES_W-1:0]     y3_reg,         y3_next;
    logic signed [RES_W-1:0]     x4_reg,         x4_next;
    logic signed [RES_W-1:0]     y4_reg,         y4_next;
    logic signed [SUM_W-1:0]     re_reg,         re_next;
    logic signed [SUM_W-1:0]     im_reg,         im_next;

    logic [COORD_BITS-1:0]       coord_sel;
    logic signed [WORD_BITS-1:0] step_sel;
    logic signed [WORD_BITS-1:0] origin_sel;
    logic signed [COORD_BITS+WORD_BITS:0] map_mul;
    logic signed [SAT_W-1:0]     map_sum;
    sat_t                        map_sat;
    sat_t                        re_sat;
    sat_t                        im_sat;
    logic                        x_big;
    logic                        y_big;
    logic [MAG2_W-1:0]           mag2;
    logic                        limit_hit;
    logic                        escaped;
    logic [OP_W-1:0]             op_a;
    logic [OP_W-1:0]             op_b;
    logic signed [RES_W-1:0]     p_s;
    logic signed [SUM_W-1:0]     p_ext;
    logic signed [SUM_W-1:0]     p5;
    logic signed [SUM_W-1:0]     p10;

    mul_req_t mul_req;
    mul_rsp_t mul_rsp;

    qetf_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    assign mul_req.start = mul_start_reg;
    assign mul_req.a     = op_a;
    assign mul_req.b     = op_b;

    // ---------------- configuration write ----------------
    assign cfg_ready = 1'b1;

    always_comb
    begin
        step_real_next   = step_real_reg;
        step_imag_next   = step_imag_reg;
        origin_real_next = origin_real_reg;
        origin_imag_next = origin_imag_reg;
        iter_limit_next  = iter_limit_reg;
        if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_STEP_REAL:   step_real_next   = signed'(cfg_data[WORD_BITS-1:0]);
                REG_STEP_IMAG:   step_imag_next   = signed'(cfg_data[WORD_BITS-1:0]);
                REG_ORIGIN_REAL: origin_real_next = signed'(cfg_data[WORD_BITS-1:0]);
                REG_ORIGIN_IMAG: origin_imag_next = signed'(cfg_data[WORD_BITS-1:0]);
                REG_ITER_LIMIT:  iter_limit_next  = cfg_data[ITER_BITS-1:0];
                default: ;  // unmapped index: ignored
            endcase
        end
    end

    // ---------------- pixel mapping (one 13x48 multiplier, used twice) ------
    assign coord_sel  = (state_reg == S_MAP_RE) ? col_reg : row_reg;
    assign step_sel   = (state_reg == S_MAP_RE) ? step_real_reg : step_imag_reg;
    assign origin_sel = (state_reg == S_MAP_IM) ? origin_real_reg : origin_imag_reg;
    assign map_mul    = signed'({1'b0, coord_sel}) * step_sel;
    assign map_sum    = SAT_W'(map_prod_reg) + SAT_W'(origin_sel);
    assign map_sat    = sat_word(map_sum);

    // ---------------- escape tests ----------------
    assign x_big     = (x_reg >= ESC_POS) || (x_reg <= ESC_NEG);
    assign y_big     = (y_reg >= ESC_POS) || (y_reg <= ESC_NEG);
    // x*x and y*y are never negative
    assign mag2      = MAG2_W'(x2_reg[RES_W-2:0]) + MAG2_W'(y2_reg[RES_W-2:0]);
    assign limit_hit = (count_reg >= lim_reg);
    assign escaped   = (count_reg < lim_reg);

    // ---------------- multiplier operand select ----------------
    always_comb
    begin
        case (op_reg)
            OP_XX:   begin op_a = OP_W'(x_reg);  op_b = OP_W'(x_reg);  end
            OP_YY:   begin op_a = OP_W'(y_reg);  op_b = OP_W'(y_reg);  end
            OP_X3:   begin op_a = OP_W'(x2_reg); op_b = OP_W'(x_reg);  end
            OP_X4:   begin op_a = OP_W'(x2_reg); op_b = OP_W'(x2_reg); end
            OP_X5:   begin op_a = OP_W'(x4_reg); op_b = OP_W'(x_reg);  end
            OP_Y3:   begin op_a = OP_W'(y2_reg); op_b = OP_W'(y_reg);  end
            OP_Y4:   begin op_a = OP_W'(y2_reg); op_b = OP_W'(y2_reg); end
            OP_Y5:   begin op_a = OP_W'(y4_reg); op_b = OP_W'(y_reg);  end
            OP_X3Y2: begin op_a = OP_W'(x3_reg); op_b = OP_W'(y2_reg); end
            OP_XY4:  begin op_a = OP_W'(x_reg);  op_b = OP_W'(y4_reg); end
            OP_YX4:  begin op_a = OP_W'(y_reg);  op_b = OP_W'(x4_reg); end
            OP_Y3X2: begin op_a = OP_W'(y3_reg); op_b = OP_W'(x2_reg); end
            default: begin op_a = '0;            op_b = '0;            end
        endcase
    end

    // Product scaled by 1, 5 and 10 for the binomial terms
    assign p_s   = signed'(mul_rsp.p);
    assign p_ext = SUM_W'(p_s);
    assign p5    = (p_ext <<< 2) + p_ext;
    assign p10   = p5 <<< 1;

    assign re_sat = sat_word(SAT_W'(re_reg));
    assign im_sat = sat_word(SAT_W'(im_reg));

    // ---------------- sequencer ----------------
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        mul_start_next = 1'b0;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        lim_next       = lim_reg;
        count_next     = count_reg;
        map_prod_next  = map_prod_reg;
        cr_next        = cr_reg;
        ci_next        = ci_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        x2_next        = x2_reg;
        y2_next        = y2_reg;
        x3_next        = x3_reg;
        y3_next        = y3_reg;
        x4_next        = x4_reg;
        y4_next        = y4_reg;
        re_next        = re_reg;
        im_next        = im_reg;

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    col_next   = s_tdata[COORD_BITS-1:0];
                    row_next   = s_tdata[2*COORD_BITS-1:COORD_BITS];
                    lim_next   = iter_limit_reg;
                    state_next = S_MAP_RE;
                end
            end
            S_MAP_RE:
            begin
                map_prod_next = map_mul;
                state_next    = S_MAP_IM;
            end
            S_MAP_IM:
            begin
                cr_next       = signed'(map_sat.value);
                map_prod_next = map_mul;
                state_next    = S_MAP_FIN;
            end
            S_MAP_FIN:
            begin
                ci_next    = signed'(map_sat.value);
                x_next     = '0;
                y_next     = '0;
                count_next = '0;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (x_big || y_big)
                begin
                    state_next = S_FINISH;
                end
                else
                begin
                    op_next        = OP_XX;
                    mul_start_next = 1'b1;
                    state_next     = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_rsp.done)
                begin
                    case (op_reg)
                        OP_XX:   x2_next = p_s;
                        OP_YY:   y2_next = p_s;
                        OP_X3:   x3_next = p_s;
                        OP_X4:   x4_next = p_s;
                        OP_X5:   re_next = re_reg + p_ext;
                        OP_Y3:   y3_next = p_s;
                        OP_Y4:   y4_next = p_s;
                        OP_Y5:   im_next = im_reg + p_ext;
                        OP_X3Y2: re_next = re_reg - p10;
                        OP_XY4:  re_next = re_reg + p5;
                        OP_YX4:  im_next = im_reg + p5;
                        OP_Y3X2: im_next = im_reg - p10;
                        default: ;
                    endcase
                    if (op_reg == OP_YY)
                    begin
                        state_next = S_TEST;
                    end
                    else if (op_reg == OP_Y3X2)
                    begin
                        state_next = S_UPDATE;
                    end
                    else
                    begin
                        op_next        = op_t'(op_reg + 4'd1);
                        mul_start_next = 1'b1;
                    end
                end
            end
            S_TEST:
            begin
                if ((mag2 >= MAG2_ESCAPE) || limit_hit)
                begin
                    state_next = S_FINISH;
                end
                else if (mag2 >= MAG2_GATE)
                begin
                    // next z certainly overflows: count it and stop
                    count_next = count_reg + 1'b1;
                    state_next = S_FINISH;
                end
                else
                begin
                    re_next        = SUM_W'(cr_reg);
                    im_next        = SUM_W'(ci_reg);
                    op_next        = OP_X3;
                    mul_start_next = 1'b1;
                    state_next     = S_MUL;
                end
            end
            S_UPDATE:
            begin
                x_next     = signed'(re_sat.value);
                y_next     = signed'(im_sat.value);
                count_next = count_reg + 1'b1;
                state_next = (re_sat.ovf || im_sat.ovf) ? S_FINISH : S_CHECK;
            end
            S_FINISH:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_data_next  = OUT_DATA_BITS'({escaped, count_reg, row_reg, col_reg});
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            op_reg          <= OP_XX;
            mul_start_reg   <= 1'b0;
            out_valid_reg   <= 1'b0;
            step_real_reg   <= '0;
            step_imag_reg   <= '0;
            origin_real_reg <= '0;
            origin_imag_reg <= '0;
            iter_limit_reg  <= LIMIT_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            op_reg          <= op_next;
            mul_start_reg   <= mul_start_next;
            out_valid_reg   <= out_valid_next;
            step_real_reg   <= step_real_next;
            step_imag_reg   <= step_imag_next;
            origin_real_reg <= origin_real_next;
            origin_imag_reg <= origin_imag_next;
            iter_limit_reg  <= iter_limit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        lim_reg      <= lim_next;
        count_reg    <= count_next;
        map_prod_reg <= map_prod_next;
        cr_reg       <= cr_next;
        ci_reg       <= ci_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        x2_reg       <= x2_next;
        y2_reg       <= y2_next;
        x3_reg       <= x3_next;
        y3_reg       <= y3_next;
        x4_reg       <= x4_next;
        y4_reg       <= y4_next;
        re_reg       <= re_next;
        im_reg       <= im_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- checks ----------------
    // multiplier is only kicked off and only answers while the sequencer waits on it
    a_mul_start_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> (state_reg == S_MUL))
        else $error("multiplier started outside product phase");

    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == S_MUL))
        else $error("multiplier result arrived outside product phase");

    // iteration count never runs past the sampled limit
    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH) |-> (count_reg <= lim_reg))
        else $error("iteration count exceeds limit");

    // a new result word only appears out of the finish step
    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == S_FINISH))
        else $error("result word raised outside finish step");

endmodule
